[design/rcrs_pkg.sv]
// Shared types, constants and the ratio compare for the RGB channel range statistics block.
// Used by rcrs_pair_fold, rgb_channel_range_stats and rcrs_checker; depends on nothing.

package rcrs_pkg;

	localparam int NUM_CHAN  = 3;
	localparam int NUM_PAIRS = 3;
	localparam int CHAN_W    = 8;
	localparam int RATIO_W   = 2 * CHAN_W;
	localparam int PIX_W     = NUM_CHAN * CHAN_W;

	localparam logic [CHAN_W-1:0]  BYTE_MAX        = 8'hFF;
	localparam logic [CHAN_W-1:0]  BYTE_ZERO       = 8'h00;
	// 255/0 sorts above every real ratio; 0/1 sorts below every real ratio
	localparam logic [RATIO_W-1:0] RATIO_MIN_RESET = 16'hFF00;
	localparam logic [RATIO_W-1:0] RATIO_MAX_RESET = 16'h0001;

	typedef logic [1:0] chan_idx_t;

	// channel pairs 01, 02 and 12
	localparam chan_idx_t PAIR_LO [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1};
	localparam chan_idx_t PAIR_HI [NUM_PAIRS] = '{2'd1, 2'd2, 2'd2};

	// running extremes of one channel pair
	typedef struct packed {
		logic [CHAN_W-1:0]  diff_min;
		logic [CHAN_W-1:0]  diff_max;
		logic [RATIO_W-1:0] ratio_min;
		logic [RATIO_W-1:0] ratio_max;
	} pair_stats_t;

	// one report, first member in the highest bits
	typedef struct packed {
		logic [NUM_PAIRS*RATIO_W-1:0] ratio_max;
		logic [NUM_PAIRS*RATIO_W-1:0] ratio_min;
		logic [NUM_PAIRS*CHAN_W-1:0]  diff_max;
		logic [NUM_PAIRS*CHAN_W-1:0]  diff_min;
		logic [NUM_CHAN*CHAN_W-1:0]   chan_max;
		logic [NUM_CHAN*CHAN_W-1:0]   chan_min;
	} report_t;

	localparam int REPORT_W = $bits(report_t);

	// a < b for numerator/denominator pairs, by cross-multiplication
	function automatic logic ratio_less(input logic [RATIO_W-1:0] a,
	                                    input logic [RATIO_W-1:0] b);
		logic [RATIO_W-1:0] lhs;
		logic [RATIO_W-1:0] rhs;
		lhs = {{CHAN_W{1'b0}}, a[RATIO_W-1:CHAN_W]} * {{CHAN_W{1'b0}}, b[CHAN_W-1:0]};
		rhs = {{CHAN_W{1'b0}}, b[RATIO_W-1:CHAN_W]} * {{CHAN_W{1'b0}}, a[CHAN_W-1:0]};
		return lhs < rhs;
	endfunction

endpackage

[design/rgb_channel_range_stats.sv]
// Top level of the RGB channel range statistics block: input register, running extremes, report.
// Depends on rcrs_pkg and rcrs_pair_fold.
//
// A frame-end pixel passes the input register and then the report register before its report shows.
// Throughput: one pixel per cycle but for the frame-end stall below, with the extremes compared combinationally.
// A frame-end pixel waits in the input register while an earlier report has not been taken.
// Reset: arst_n clears all extremes to their empty values (minima 255, maxima 0, ratio 255/0
// and 0/1) and empties the input and report registers at once.

module rgb_channel_range_stats (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// fields from bit 0 up: chan0[7:0], chan1[15:8], chan2[23:16]
	input  logic [rcrs_pkg::PIX_W-1:0]    s_axis_tdata,
	// frame_end
	input  logic                          s_axis_tlast,

	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// fields from bit 0 up: chan_min_packed[23:0], chan_max_packed[47:24],
	// diff_min_packed[71:48], diff_max_packed[95:72], ratio_min_packed[143:96],
	// ratio_max_packed[191:144]
	output logic [rcrs_pkg::REPORT_W-1:0] m_axis_tdata
);

	// input register stage
	logic                        valid_s1;
	logic                        last_s1;
	logic [rcrs_pkg::CHAN_W-1:0] chan_s1 [rcrs_pkg::NUM_CHAN];

	// running extremes
	logic [rcrs_pkg::CHAN_W-1:0] chan_min_q [rcrs_pkg::NUM_CHAN];
	logic [rcrs_pkg::CHAN_W-1:0] chan_max_q [rcrs_pkg::NUM_CHAN];
	rcrs_pkg::pair_stats_t       pair_q     [rcrs_pkg::NUM_PAIRS];

	// next values
	logic [rcrs_pkg::CHAN_W-1:0] chan_min_nxt [rcrs_pkg::NUM_CHAN];
	logic [rcrs_pkg::CHAN_W-1:0] chan_max_nxt [rcrs_pkg::NUM_CHAN];
	rcrs_pkg::pair_stats_t       pair_nxt     [rcrs_pkg::NUM_PAIRS];
	rcrs_pkg::report_t           report_nxt;

	// report register
	logic                        out_valid_q;
	rcrs_pkg::report_t           report_q;

	logic out_free;
	logic advance_s1;
	logic all_nonzero;

	// The report register frees when empty or when its transfer completes this cycle.
	assign out_free   = !out_valid_q || m_axis_tready;
	// Ordinary pixels always fold in; a frame-end pixel needs a free report slot.
	assign advance_s1 = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance_s1;

	// Hold the pixel in the input register until it folds into the extremes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			last_s1 <= s_axis_tlast;
			for (int i = 0; i < rcrs_pkg::NUM_CHAN; i++) begin
				chan_s1[i] <= s_axis_tdata[i*rcrs_pkg::CHAN_W +: rcrs_pkg::CHAN_W];
			end
		end
	end

	// Channel extremes; min and max compare on their own, never as an either/or.
	always_comb begin
		for (int i = 0; i < rcrs_pkg::NUM_CHAN; i++) begin
			chan_min_nxt[i] = (chan_s1[i] < chan_min_q[i]) ? chan_s1[i] : chan_min_q[i];
			chan_max_nxt[i] = (chan_s1[i] > chan_max_q[i]) ? chan_s1[i] : chan_max_q[i];
		end
	end

	// Ratios only count when no channel is zero.
	assign all_nonzero = (chan_s1[0] != rcrs_pkg::BYTE_ZERO) &&
	                     (chan_s1[1] != rcrs_pkg::BYTE_ZERO) &&
	                     (chan_s1[2] != rcrs_pkg::BYTE_ZERO);

	for (genvar p = 0; p < rcrs_pkg::NUM_PAIRS; p++) begin : g_pair
		rcrs_pair_fold u_fold (
			.x        (chan_s1[rcrs_pkg::PAIR_LO[p]]),
			.y        (chan_s1[rcrs_pkg::PAIR_HI[p]]),
			.do_ratio (all_nonzero),
			.cur      (pair_q[p]),
			.nxt      (pair_nxt[p])
		);
	end

	// Advance the extremes whenever the held pixel folds in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcrs_pkg::NUM_CHAN; i++) begin
				chan_min_q[i] <= rcrs_pkg::BYTE_MAX;
				chan_max_q[i] <= rcrs_pkg::BYTE_ZERO;
			end
			for (int p = 0; p < rcrs_pkg::NUM_PAIRS; p++) begin
				pair_q[p].diff_min  <= rcrs_pkg::BYTE_MAX;
				pair_q[p].diff_max  <= rcrs_pkg::BYTE_ZERO;
				pair_q[p].ratio_min <= rcrs_pkg::RATIO_MIN_RESET;
				pair_q[p].ratio_max <= rcrs_pkg::RATIO_MAX_RESET;
			end
		end else if (advance_s1) begin
			for (int i = 0; i < rcrs_pkg::NUM_CHAN; i++) begin
				chan_min_q[i] <= chan_min_nxt[i];
				chan_max_q[i] <= chan_max_nxt[i];
			end
			for (int p = 0; p < rcrs_pkg::NUM_PAIRS; p++) begin
				pair_q[p] <= pair_nxt[p];
			end
		end
	end

	// Pack the report from the updated extremes, so the frame-end pixel is included.
	always_comb begin
		for (int i = 0; i < rcrs_pkg::NUM_CHAN; i++) begin
			report_nxt.chan_min[i*rcrs_pkg::CHAN_W +: rcrs_pkg::CHAN_W] = chan_min_nxt[i];
			report_nxt.chan_max[i*rcrs_pkg::CHAN_W +: rcrs_pkg::CHAN_W] = chan_max_nxt[i];
		end
		for (int p = 0; p < rcrs_pkg::NUM_PAIRS; p++) begin
			report_nxt.diff_min[p*rcrs_pkg::CHAN_W +: rcrs_pkg::CHAN_W]    = pair_nxt[p].diff_min;
			report_nxt.diff_max[p*rcrs_pkg::CHAN_W +: rcrs_pkg::CHAN_W]    = pair_nxt[p].diff_max;
			report_nxt.ratio_min[p*rcrs_pkg::RATIO_W +: rcrs_pkg::RATIO_W] = pair_nxt[p].ratio_min;
			report_nxt.ratio_max[p*rcrs_pkg::RATIO_W +: rcrs_pkg::RATIO_W] = pair_nxt[p].ratio_max;
		end
	end

	// Hold the report until its transfer on the master side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			report_q <= report_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = report_q;

endmodule

[design/rcrs_pair_fold.sv]
// Next-state logic for one channel pair: absolute difference and larger/smaller ratio extremes.
// Depends on rcrs_pkg.

module rcrs_pair_fold (
	input  logic [rcrs_pkg::CHAN_W-1:0] x,
	input  logic [rcrs_pkg::CHAN_W-1:0] y,
	input  logic                        do_ratio,
	input  rcrs_pkg::pair_stats_t       cur,
	output rcrs_pkg::pair_stats_t       nxt
);

	logic [rcrs_pkg::CHAN_W-1:0]  big;
	logic [rcrs_pkg::CHAN_W-1:0]  sml;
	logic [rcrs_pkg::CHAN_W-1:0]  diff;
	logic [rcrs_pkg::RATIO_W-1:0] ratio;

	assign big   = (x > y) ? x : y;
	assign sml   = (x > y) ? y : x;
	assign diff  = big - sml;
	assign ratio = {big, sml};

	always_comb begin
		nxt = cur;
		if (diff < cur.diff_min) begin
			nxt.diff_min = diff;
		end
		if (diff > cur.diff_max) begin
			nxt.diff_max = diff;
		end
		if (do_ratio) begin
			if (rcrs_pkg::ratio_less(ratio, cur.ratio_min)) begin
				nxt.ratio_min = ratio;
			end
			if (rcrs_pkg::ratio_less(cur.ratio_max, ratio)) begin
				nxt.ratio_max = ratio;
			end
		end
	end

endmodule

[design/rcrs_checker.sv]
// Port-level checks for rgb_channel_range_stats and the bind that attaches them.
// Depends on rcrs_pkg and the top level's ports.

module rcrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tlast,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [rcrs_pkg::REPORT_W-1:0] m_axis_tdata
);

	rcrs_pkg::report_t rep;

	assign rep = m_axis_tdata;

	// a stalled report stays valid
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("report dropped while stalled");

	// a stalled report keeps its data
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("report changed while stalled");

	// the slave side only stalls behind a waiting report
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with report register empty");

	// every report follows at least one pixel, so each channel and difference minimum is at most its maximum
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(rep.chan_min[7:0]   <= rep.chan_max[7:0])   &&
			(rep.chan_min[15:8]  <= rep.chan_max[15:8])  &&
			(rep.chan_min[23:16] <= rep.chan_max[23:16]) &&
			(rep.diff_min[7:0]   <= rep.diff_max[7:0])   &&
			(rep.diff_min[15:8]  <= rep.diff_max[15:8])  &&
			(rep.diff_min[23:16] <= rep.diff_max[23:16]))
		else $error("reported minimum above maximum");

	// a fresh report only rises after a frame-end transfer on the slave side
	a_report_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
		else $error("report appeared without a frame-end transfer");

endmodule

bind rgb_channel_range_stats rcrs_checker u_rcrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
